[hw/rtl/nesc_pkg.sv]
// Shared types, constants and the sigmoid table builder of the neuron Euler step unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nesc_pkg;

	// Sigmoid lookup geometry.
	localparam int unsigned SIGMOID_TABLE_DEPTH = 1024;
	localparam int unsigned SIG_IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int unsigned DEPTH_W = $clog2(SIGMOID_TABLE_DEPTH + 1);

	// Fixed-point constants, voltages in signed Q8.24 millivolts.
	localparam logic signed [63:0] MV = 64'sd16777216;
	localparam logic signed [63:0] NA_MIDPOINT = -64'sd20 * MV;
	localparam logic signed [63:0] K_MIDPOINT = -64'sd25 * MV;
	localparam logic [63:0] NA_SLOPE = 64'd15;
	localparam logic [63:0] K_SLOPE = 64'd5;
	localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
	localparam int unsigned HALVINGS = 16;
	localparam logic signed [33:0] K_REV_OFFSET = 34'sd1509949440;
	localparam logic [31:0] GATE_ONE = 32'h8000_0000;

	// Configuration register map.
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_INPUT_DRIVE     = 3'd0,
		REG_LEAK_GAIN       = 3'd1,
		REG_SODIUM_GAIN     = 3'd2,
		REG_POTASSIUM_GAIN  = 3'd3,
		REG_GATE_RATE       = 3'd4,
		REG_SPIKE_THRESHOLD = 3'd5,
		REG_LEAK_REVERSAL   = 3'd6,
		REG_SODIUM_REVERSAL = 3'd7
	} reg_idx_t;

	localparam logic [31:0] REG_RESET [NUM_REGS] = '{
		32'd0, 32'd343597, 32'd858993, 32'd386547, 32'd282564,
		32'hE700_0000, 32'hB000_0000, 32'h3C00_0000
	};

	// Operations issued to the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_NA_GAIN,
		MUL_K_GAIN,
		MUL_LEAK,
		MUL_NA,
		MUL_K,
		MUL_GATE
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INDEX,
		ST_ROM,
		ST_MUL_NA_GAIN,
		ST_MUL_K_GAIN,
		ST_MUL_LEAK,
		ST_MUL_NA,
		ST_MUL_K,
		ST_MUL_GATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    index_en;
		logic    rom_en;
		logic    acc_init;
		logic    gna_en;
		logic    gk_en;
		logic    acc_sub;
		mul_op_t mul_op;
		logic    finish;
	} ctrl_t;

	typedef logic [31:0] sig_table_t [SIGMOID_TABLE_DEPTH];

	// Upper bits of a Q2.62 product, truncated.
	function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Restoring division, evaluated only while the tables are elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Logistic curve at voltage v; k_curve selects the potassium curve.
	function automatic logic [31:0] sig_entry(input logic signed [63:0] v, input logic k_curve);
		logic signed [63:0] d;
		logic [63:0] a, z, z2, z3, z4, e, e32, den, num, quo;
		d = v - (k_curve ? K_MIDPOINT : NA_MIDPOINT);
		a = d[63] ? 64'(-d) : 64'(d);
		z = k_curve ? (a << 22) / K_SLOPE : (a << 22) / NA_SLOPE;
		z2 = mul62(z, z);
		z3 = mul62(z2, z);
		z4 = mul62(z3, z);
		e = Q62_ONE - z + (z2 / 64'd2) - (z3 / 64'd6) + (z4 / 64'd24);
		for (int i = 0; i < int'(HALVINGS); i++) begin
			e = mul62(e, e);
		end
		e32 = e >> 30;
		den = 64'h1_0000_0000 + e32;
		num = d[63] ? (e32 << 31) : 64'h8000_0000_0000_0000;
		quo = udiv64(num + (den >> 1), den);
		return quo[31:0];
	endfunction

	// Whole table, one entry per voltage bin, sampled at the bin center.
	function automatic sig_table_t build_sig_table(input logic k_curve);
		sig_table_t tbl;
		logic [63:0] t;
		logic signed [63:0] vc;
		for (int i = 0; i < int'(SIGMOID_TABLE_DEPTH); i++) begin
			t = ((64'd2 * 64'(i) + 64'd1) << 31) / 64'(SIGMOID_TABLE_DEPTH);
			vc = $signed(t) - 64'sd2147483648;
			tbl[i] = sig_entry(vc, k_curve);
		end
		return tbl;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/neuron_euler_step_spike_counter_unit.sv]
// Top level of the neuron Euler step unit: configuration registers, neuron state,
// datapath and stream ports. Uses nesc_pkg, nesc_ctrl, nesc_mul_unit, nesc_sigmoid_rom.
//
// Each request on the slave stream advances a persistent-sodium / potassium neuron
// by one forward-Euler step and yields one result on the master stream. With the
// restart flag in s_tuser the start voltage and gate are loaded and the crossing
// count is cleared before the step. The result carries the new voltage, the new
// gate, the running crossing count, and in m_tuser whether the voltage rose
// through the threshold on this step.
// From acceptance to m_tvalid an item passes through the table index, a registered
// table read, then six products through one shared 32x32 multiplier under the
// sequencer. The next request is accepted the cycle after the result is written,
// so no new item is taken while one is in work; s_tready is high only while
// the sequencer is idle. A finished result waits in the output register; if the
// receiver stalls, the next item is still accepted and computed, and it is held
// in its last step until the output register frees up.
// Configuration writes take effect at once and belong in idle periods.
// Reset clears the voltage, gate and count and loads the default register values.
`default_nettype none

module neuron_euler_step_spike_counter_unit
	import nesc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [63:0]          s_tdata,  // start_voltage[31:0], start_gate[63:32]
	input  wire logic [0:0]           s_tuser,  // restart[0]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [95:0]          m_tdata,  // voltage[31:0], gate[63:32], crossing_count[95:64]
	output logic      [0:0]           m_tuser,  // crossed[0]
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	ctrl_t ctrl;
	logic  out_free;

	logic [31:0] cfg_q [NUM_REGS];

	logic signed [31:0] v_q;
	logic        [31:0] n_q;
	logic        [31:0] cnt_q;

	logic [SIG_IDX_W-1:0]    idx_q;
	logic [31+DEPTH_W:0]     idx_prod;
	logic [31:0]             m_sig;
	logic [31:0]             q_sig;
	logic [31:0]             gna_q;
	logic [31:0]             gk_q;
	logic signed [35:0]      acc_q;

	logic signed [33:0] mul_x;
	logic        [31:0] mul_g;
	logic        [63:0] prod;
	logic               prod_neg;
	logic signed [33:0] scaled;

	logic signed [31:0] vn_sat;
	logic signed [34:0] gate_sum;
	logic        [31:0] gate_new;
	logic               crossed;
	logic signed [31:0] thr;

	logic               m_tvalid_q;
	logic signed [31:0] out_v_q;
	logic        [31:0] out_n_q;
	logic        [31:0] out_cnt_q;
	logic               out_crossed_q;

	logic [31:0] start_gate;

	assign out_free = !m_tvalid_q || m_tready;

	nesc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.ready    (s_tready),
		.ctrl     (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(NUM_REGS); i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign start_gate = (s_tdata[63:32] > GATE_ONE) ? GATE_ONE : s_tdata[63:32];

	// Neuron state, loaded on restart and updated when a result is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.accept && s_tuser[0]) begin
			v_q <= $signed(s_tdata[31:0]);
			n_q <= start_gate;
			cnt_q <= '0;
		end else if (ctrl.finish) begin
			v_q <= vn_sat;
			n_q <= gate_new;
			if (crossed && (cnt_q != 32'hFFFF_FFFF)) cnt_q <= cnt_q + 32'd1;
		end
	end

	// Voltage bin: offset-binary voltage scaled by the table depth, top bits kept.
	assign idx_prod = {{DEPTH_W{1'b0}}, (v_q ^ 32'h8000_0000)}
		* (32 + DEPTH_W)'(SIGMOID_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (ctrl.index_en) idx_q <= idx_prod[32 +: SIG_IDX_W];
	end

	nesc_sigmoid_rom u_rom (
		.clk    (clk),
		.en     (ctrl.rom_en),
		.addr   (idx_q),
		.na_sig (m_sig),
		.k_sig  (q_sig)
	);

	always_comb begin
		unique case (ctrl.mul_op)
			MUL_NA_GAIN: begin
				mul_x = $signed({2'b00, m_sig});
				mul_g = cfg_q[REG_SODIUM_GAIN];
			end
			MUL_K_GAIN: begin
				mul_x = $signed({2'b00, n_q});
				mul_g = cfg_q[REG_POTASSIUM_GAIN];
			end
			MUL_LEAK: begin
				mul_x = 34'(v_q) - 34'($signed(cfg_q[REG_LEAK_REVERSAL]));
				mul_g = cfg_q[REG_LEAK_GAIN];
			end
			MUL_NA: begin
				mul_x = 34'(v_q) - 34'($signed(cfg_q[REG_SODIUM_REVERSAL]));
				mul_g = gna_q;
			end
			MUL_K: begin
				mul_x = 34'(v_q) + K_REV_OFFSET;
				mul_g = gk_q;
			end
			MUL_GATE: begin
				mul_x = $signed({2'b00, q_sig}) - $signed({2'b00, n_q});
				mul_g = cfg_q[REG_GATE_RATE];
			end
			default: begin
				mul_x = '0;
				mul_g = '0;
			end
		endcase
	end

	nesc_mul_unit u_mul (
		.clk  (clk),
		.en   (ctrl.mul_op != MUL_NONE),
		.x    (mul_x),
		.g    (mul_g),
		.prod (prod),
		.neg  (prod_neg)
	);

	// Scaled term rounds toward zero: the magnitude is truncated, then the sign applied.
	assign scaled = prod_neg ? -$signed({2'b00, prod[63:32]}) : $signed({2'b00, prod[63:32]});

	always_ff @(posedge clk) begin
		if (ctrl.gna_en) gna_q <= prod[62:31];
		if (ctrl.gk_en) gk_q <= prod[62:31];
		if (ctrl.acc_init) begin
			acc_q <= 36'(v_q) + 36'($signed(cfg_q[REG_INPUT_DRIVE]));
		end else if (ctrl.acc_sub) begin
			acc_q <= acc_q - 36'(scaled);
		end
	end

	always_comb begin
		if (acc_q > 36'sd2147483647) begin
			vn_sat = 32'sh7FFF_FFFF;
		end else if (acc_q < -36'sd2147483648) begin
			vn_sat = 32'sh8000_0000;
		end else begin
			vn_sat = acc_q[31:0];
		end
		gate_sum = $signed({3'b000, n_q}) + 35'(scaled);
		if (gate_sum < 35'sd0) begin
			gate_new = '0;
		end else if (gate_sum > $signed({3'b000, GATE_ONE})) begin
			gate_new = GATE_ONE;
		end else begin
			gate_new = gate_sum[31:0];
		end
		thr = $signed(cfg_q[REG_SPIKE_THRESHOLD]);
		crossed = (vn_sat > thr) && (v_q < thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			out_v_q <= vn_sat;
			out_n_q <= gate_new;
			out_crossed_q <= crossed;
			out_cnt_q <= (crossed && (cnt_q != 32'hFFFF_FFFF)) ? cnt_q + 32'd1 : cnt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_cnt_q, out_n_q, out_v_q};
	assign m_tuser = out_crossed_q;

endmodule

`default_nettype wire

[hw/rtl/nesc_sigmoid_rom.sv]
// Sodium and potassium steady-state activation tables with a registered read port.
// Table contents are built from nesc_pkg at elaboration.
`default_nettype none

module nesc_sigmoid_rom
	import nesc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [SIG_IDX_W-1:0] addr,
	output logic      [31:0]          na_sig,
	output logic      [31:0]          k_sig
);

	localparam sig_table_t NA_TABLE = build_sig_table(1'b0);
	localparam sig_table_t K_TABLE = build_sig_table(1'b1);

	logic [31:0] na_q;
	logic [31:0] k_q;

	always_ff @(posedge clk) begin
		if (en) begin
			na_q <= NA_TABLE[addr];
			k_q <= K_TABLE[addr];
		end
	end

	assign na_sig = na_q;
	assign k_sig = k_q;

endmodule

`default_nettype wire

[hw/rtl/nesc_mul_unit.sv]
// Shared sign-magnitude multiplier: |x| (clamped to 32 bits) times an unsigned gain.
// The product and the operand sign are registered. Uses nesc_pkg.
`default_nettype none

module nesc_mul_unit
	import nesc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [33:0] x,
	input  wire logic        [31:0] g,
	output logic             [63:0] prod,
	output logic                    neg
);

	logic [33:0] mag;
	logic [31:0] mag32;
	logic [63:0] prod_q;
	logic        neg_q;

	always_comb begin
		mag = x[33] ? 34'(-x) : 34'(x);
		mag32 = (mag[33:32] != 2'b00) ? 32'hFFFF_FFFF : mag[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {32'd0, mag32} * {32'd0, g};
			neg_q <= x[33];
		end
	end

	assign prod = prod_q;
	assign neg = neg_q;

endmodule

`default_nettype wire

[hw/rtl/nesc_ctrl.sv]
// Step sequencer: walks one item through index, table read and six multiplies.
// Drives the datapath through a ctrl_t bundle from nesc_pkg.
`default_nettype none

module nesc_ctrl
	import nesc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic out_free,
	output logic      ready,
	output ctrl_t     ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_INDEX;
			end
			ST_INDEX:       state_d = ST_ROM;
			ST_ROM:         state_d = ST_MUL_NA_GAIN;
			ST_MUL_NA_GAIN: state_d = ST_MUL_K_GAIN;
			ST_MUL_K_GAIN:  state_d = ST_MUL_LEAK;
			ST_MUL_LEAK:    state_d = ST_MUL_NA;
			ST_MUL_NA:      state_d = ST_MUL_K;
			ST_MUL_K:       state_d = ST_MUL_GATE;
			ST_MUL_GATE:    state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:        state_d = ST_IDLE;
		endcase
	end

	// Each multiply state after the first also consumes the product issued in the state before it; done consumes the last.
	always_comb begin
		ctrl = '0;
		ctrl.mul_op = MUL_NONE;
		ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				ctrl.accept = in_valid;
			end
			ST_INDEX: ctrl.index_en = 1'b1;
			ST_ROM: begin
				ctrl.rom_en = 1'b1;
				ctrl.acc_init = 1'b1;
			end
			ST_MUL_NA_GAIN: ctrl.mul_op = MUL_NA_GAIN;
			ST_MUL_K_GAIN: begin
				ctrl.mul_op = MUL_K_GAIN;
				ctrl.gna_en = 1'b1;
			end
			ST_MUL_LEAK: begin
				ctrl.mul_op = MUL_LEAK;
				ctrl.gk_en = 1'b1;
			end
			ST_MUL_NA: begin
				ctrl.mul_op = MUL_NA;
				ctrl.acc_sub = 1'b1;
			end
			ST_MUL_K: begin
				ctrl.mul_op = MUL_K;
				ctrl.acc_sub = 1'b1;
			end
			ST_MUL_GATE: begin
				ctrl.mul_op = MUL_GATE;
				ctrl.acc_sub = 1'b1;
			end
			ST_DONE: ctrl.finish = out_free;
			default: ctrl = '0;
		endcase
	end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of neuron_euler_step_spike_counter_unit: random stream traffic
// on both sides, checked against an in-bench Euler step predictor. Depends on nesc_pkg.
`default_nettype none

module tb_top;
	import nesc_pkg::*;

	typedef struct packed {
		logic        restart;
		logic [31:0] start_voltage;
		logic [31:0] start_gate;
	} step_req_t;

	typedef struct packed {
		logic [31:0] voltage;
		logic [31:0] gate;
		logic        crossed;
		logic [31:0] crossing_count;
	} step_res_t;

	typedef logic [31:0] reg_file_t [NUM_REGS];

	localparam longint MILLIVOLT = 64'sd16777216;
	localparam longint K_REVERSAL = -64'sd90 * MILLIVOLT;
	localparam longint NA_HALF_POINT = -64'sd20 * MILLIVOLT;
	localparam longint K_HALF_POINT = -64'sd25 * MILLIVOLT;
	localparam logic [31:0] GATE_FULL = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;   // start_voltage[31:0], start_gate[63:32]
	logic [0:0] s_tuser = '0;    // restart[0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;        // voltage[31:0], gate[63:32], crossing_count[95:64]
	logic [0:0] m_tuser;         // crossed[0]
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Predictor state: registers, neuron state and the two activation curves.
	logic [31:0] cfg_shadow [NUM_REGS];
	logic [31:0] volt_state = '0;
	logic [31:0] gate_state = '0;
	logic [31:0] count_state = '0;
	logic [31:0] na_curve [SIGMOID_TABLE_DEPTH];
	logic [31:0] k_curve [SIGMOID_TABLE_DEPTH];

	step_req_t pending_steps [$];
	step_res_t predicted_steps [$];
	step_req_t in_flight;
	step_res_t oldest_step;
	bit holding;
	bit source_steady = 1'b0;
	bit sink_steady = 1'b0;
	int send_wait = 0;
	int hold_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;

	neuron_euler_step_spike_counter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint signed32(input logic [31:0] x);
		return longint'($signed(x));
	endfunction

	function automatic logic [31:0] mv(input int x);
		return 32'(longint'(x) * MILLIVOLT);
	endfunction

	// Uniform voltage within plus or minus span millivolts.
	function automatic logic [31:0] near_mv(input int unsigned span);
		return $urandom_range(0, (2 * span) << 24) - (span << 24);
	endfunction

	// Q2.62 product, low bits dropped.
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] wide;
		wide = 128'(a) * 128'(b);
		wide = wide >> 62;
		return wide[63:0];
	endfunction

	// Logistic 1/(1+exp((mid-v)/slope)) in Q1.31; exp of a small argument by a
	// five-term series, then squared up sixteen times.
	function automatic logic [31:0] logistic_q31(input longint v, input longint mid,
			input logic [63:0] slope);
		longint d;
		logic [63:0] mag, z, z2, z3, z4, e, e32, den, num, quot;
		d = v - mid;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		z = (mag << 22) / slope;
		z2 = q62_mul(z, z);
		z3 = q62_mul(z2, z);
		z4 = q62_mul(z3, z);
		e = 64'h4000_0000_0000_0000 - z + z2 / 64'd2 - z3 / 64'd6 + z4 / 64'd24;
		repeat (16) e = q62_mul(e, e);
		e32 = e >> 30;
		den = 64'h1_0000_0000 + e32;
		num = (d < 0) ? (e32 << 31) : 64'h8000_0000_0000_0000;
		quot = (num + den / 64'd2) / den;
		return quot[31:0];
	endfunction

	// x times a Q0.32 gain, magnitude capped at 32 bits, rounded toward zero.
	function automatic longint scaled_toward_zero(input longint x, input logic [63:0] g);
		logic [63:0] mag, r;
		mag = (x < 0) ? 64'(-x) : 64'(x);
		if (mag > 64'hFFFF_FFFF)
			mag = 64'hFFFF_FFFF;
		r = (mag * g) >> 32;
		return (x < 0) ? -$signed(r) : $signed(r);
	endfunction

	task automatic euler_step_predict(input step_req_t req);
		longint v, vn, thr, gate_next;
		logic [63:0] bin, m_act, q_act, n_act, gna, gk;
		step_res_t res;
		if (req.restart) begin
			volt_state = req.start_voltage;
			gate_state = (req.start_gate > GATE_FULL) ? GATE_FULL : req.start_gate;
			count_state = '0;
		end
		v = signed32(volt_state);
		n_act = 64'(gate_state);
		bin = (64'(volt_state ^ 32'h8000_0000) * 64'(SIGMOID_TABLE_DEPTH)) >> 32;
		m_act = 64'(na_curve[int'(bin)]);
		q_act = 64'(k_curve[int'(bin)]);
		gna = (64'(cfg_shadow[REG_SODIUM_GAIN]) * m_act) >> 31;
		gk = (64'(cfg_shadow[REG_POTASSIUM_GAIN]) * n_act) >> 31;
		vn = v + signed32(cfg_shadow[REG_INPUT_DRIVE])
			- scaled_toward_zero(v - signed32(cfg_shadow[REG_LEAK_REVERSAL]),
				64'(cfg_shadow[REG_LEAK_GAIN]))
			- scaled_toward_zero(v - signed32(cfg_shadow[REG_SODIUM_REVERSAL]), gna)
			- scaled_toward_zero(v - K_REVERSAL, gk);
		if (vn > 64'sd2147483647)
			vn = 64'sd2147483647;
		if (vn < -64'sd2147483648)
			vn = -64'sd2147483648;
		gate_next = $signed(n_act) + scaled_toward_zero($signed(q_act) - $signed(n_act),
			64'(cfg_shadow[REG_GATE_RATE]));
		if (gate_next < 0)
			gate_next = 0;
		if (gate_next > longint'(GATE_FULL))
			gate_next = longint'(GATE_FULL);
		thr = signed32(cfg_shadow[REG_SPIKE_THRESHOLD]);
		res.crossed = (vn > thr) && (v < thr);
		if (res.crossed && count_state != '1)
			count_state++;
		volt_state = 32'(vn);
		gate_state = 32'(gate_next);
		res.voltage = volt_state;
		res.gate = gate_state;
		res.crossing_count = count_state;
		predicted_steps.push_back(res);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	function automatic int idle_draw(input bit steady);
		return steady ? 0 : int'($urandom_range(0, 13));
	endfunction

	// Request side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_wait = 0;
		end else begin
			holding = s_tvalid;
			if (s_tvalid && s_tready) begin
				euler_step_predict(in_flight);
				holding = 1'b0;
				send_wait = idle_draw(source_steady);
				if ($urandom_range(0, 39) == 0)
					source_steady = !source_steady;
			end
			if (!holding) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_steps.size() > 0) begin
					in_flight = pending_steps.pop_front();
					s_tdata <= {in_flight.start_gate, in_flight.start_voltage};
					s_tuser <= in_flight.restart;
					holding = 1'b1;
				end
			end
			s_tvalid <= holding;
		end
	end

	// Result side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (predicted_steps.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no step outstanding",
						results_seen));
				end else begin
					oldest_step = predicted_steps.pop_front();
					if (m_tdata[31:0] !== oldest_step.voltage)
						report_mismatch($sformatf("result %0d voltage %h, expected %h",
							results_seen, m_tdata[31:0], oldest_step.voltage));
					if (m_tdata[63:32] !== oldest_step.gate)
						report_mismatch($sformatf("result %0d gate %h, expected %h",
							results_seen, m_tdata[63:32], oldest_step.gate));
					if (m_tdata[95:64] !== oldest_step.crossing_count)
						report_mismatch($sformatf("result %0d crossing_count %0d, expected %0d",
							results_seen, m_tdata[95:64], oldest_step.crossing_count));
					if (m_tuser[0] !== oldest_step.crossed)
						report_mismatch($sformatf("result %0d crossed %b, expected %b",
							results_seen, m_tuser[0], oldest_step.crossed));
				end
				results_seen++;
				hold_cycles = idle_draw(sink_steady);
				if ($urandom_range(0, 39) == 0)
					sink_steady = !sink_steady;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic queue_step(input logic restart, input logic [31:0] v,
			input logic [31:0] g);
		step_req_t req;
		req.restart = restart;
		req.start_voltage = v;
		req.start_gate = g;
		pending_steps.push_back(req);
	endtask

	function automatic logic [31:0] pick_start_voltage();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return cfg_shadow[REG_SPIKE_THRESHOLD] - $urandom_range(1, 32'h0010_0000);
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			3: return mv(80) + near_mv(40);
			default: return near_mv(100);
		endcase
	endfunction

	function automatic logic [31:0] pick_start_gate();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return GATE_FULL;
			2: return 32'd0;
			default: return $urandom_range(0, 32'h8000_0000);
		endcase
	endfunction

	// Mostly a restart followed by a run of free steps; now and then a run
	// that carries on from wherever the neuron stands.
	task automatic queue_random_run(input int count);
		int left;
		int run;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) != 0) begin
				queue_step(1'b1, pick_start_voltage(), pick_start_gate());
				left--;
			end
			run = $urandom_range(0, 30);
			while (run > 0 && left > 0) begin
				queue_step(1'b0, $urandom(), $urandom());
				run--;
				left--;
			end
		end
	endtask

	function automatic logic [31:0] draw_reg(input reg_idx_t idx);
		case (idx)
			REG_LEAK_GAIN, REG_SODIUM_GAIN, REG_POTASSIUM_GAIN, REG_GATE_RATE:
				case ($urandom_range(0, 3))
					0: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
					1: return $urandom();
					default: return $urandom_range(0, 32'h2000_0000);
				endcase
			REG_INPUT_DRIVE:
				return ($urandom_range(0, 3) == 0) ? $urandom() : near_mv(2);
			default:
				return ($urandom_range(0, 3) == 0) ? $urandom() : near_mv(100);
		endcase
	endfunction

	// Returns once every request is through and every result is back.
	task automatic drain();
		do @(negedge clk);
		while (pending_steps.size() != 0 || s_tvalid || predicted_steps.size() != 0);
		repeat (14) @(posedge clk);
	endtask

	task automatic apply_setting(input reg_file_t setting);
		drain();
		for (int r = 0; r < NUM_REGS; r++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(r);
			cfg_data <= setting[r];
			cfg_shadow[r] = setting[r];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		reg_file_t setting;
		longint center;
		for (int i = 0; i < int'(SIGMOID_TABLE_DEPTH); i++) begin
			center = $signed(((64'd2 * 64'(i) + 64'd1) << 31) / 64'(SIGMOID_TABLE_DEPTH))
				- 64'sd2147483648;
			na_curve[i] = logistic_q31(center, NA_HALF_POINT, 64'd15);
			k_curve[i] = logistic_q31(center, K_HALF_POINT, 64'd5);
		end
		cfg_shadow = '{32'd0, 32'd343597, 32'd858993, 32'd386547, 32'd282564,
			32'hE700_0000, 32'hB000_0000, 32'h3C00_0000};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: step from the cleared state, gate above one,
		// voltage extremes, and a start just under the threshold.
		queue_step(1'b0, $urandom(), $urandom());
		queue_step(1'b1, mv(-65), 32'd0);
		queue_step(1'b0, $urandom(), $urandom());
		queue_step(1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_step(1'b1, 32'h7FFF_FFFF, 32'h8000_0001);
		queue_step(1'b1, mv(-25) - 32'd1, GATE_FULL);
		queue_step(1'b0, $urandom(), $urandom());
		queue_step(1'b1, mv(-25), 32'h4000_0000);

		// Every register at its top value, then at its bottom value; the voltage saturates.
		setting = '{32'h7FFF_FFFF, '1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		apply_setting(setting);
		queue_step(1'b1, 32'h7FFF_FFFF, GATE_FULL);
		queue_step(1'b0, $urandom(), $urandom());
		queue_step(1'b1, 32'h8000_0000, 32'd0);
		setting = '{32'h8000_0000, '0, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		apply_setting(setting);
		queue_step(1'b1, 32'h8000_0000, 32'd0);
		queue_step(1'b0, $urandom(), $urandom());
		queue_step(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

		// Leak and sodium gains near one with both reversals at 80 mV reflect the
		// voltage about 80 mV on each step, so it crosses the threshold every other step.
		setting = '{32'd0, '1, '1, 32'd0, 32'h1000_0000, mv(80), mv(80), mv(80)};
		apply_setting(setting);
		queue_step(1'b1, mv(40), 32'd0);
		repeat (8) queue_step(1'b0, $urandom(), $urandom());
		queue_random_run(150);

		repeat (6) begin
			for (int r = 0; r < NUM_REGS; r++)
				setting[r] = draw_reg(reg_idx_t'(r));
			apply_setting(setting);
			queue_random_run(235);
		end

		drain();
		if (mismatches == 0)
			$display("neuron_euler_step_spike_counter_unit verification clean");
		else
			$display("neuron_euler_step_spike_counter_unit verification failed");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("neuron_euler_step_spike_counter_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
